// File: design/parallel_copy_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Parallel copy sequencer assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_COPY_SEQUENCER_CORE_MACROS_SVH
`define PARALLEL_COPY_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcs check failed");

// Next-cycle implication, disabled during reset
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcs check failed");

`endif

// File: design/pcs_pkg.sv
// ----------------------------------------------------------------------------
// Parallel copy sequencer package
// Sizes, payload types, cell opcodes and chain control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    localparam int MAX_COPIES = 16;
    localparam int MAX_MOVES  = MAX_COPIES + MAX_COPIES / 2;
    localparam int CNT_W      = $clog2(MAX_COPIES + 1);
    localparam int POS_W      = $clog2(MAX_COPIES);
    localparam int MCNT_W     = $clog2(MAX_MOVES + 1);
    localparam int REG_W      = 16;
    localparam int KIND_W     = 8;

    // Cell opcodes
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_SHIFT = 2'd1;
    localparam logic [1:0] CELL_REDIR = 2'd2;
    localparam logic [1:0] CELL_CLEAR = 2'd3;

    typedef struct packed {
        logic [REG_W-1:0]  copy_dst;
        logic [REG_W-1:0]  copy_src;
        logic [KIND_W-1:0] copy_kind;
        logic              last_copy;
    } copy_req_t;

    typedef struct packed {
        logic [REG_W-1:0]  move_dst;
        logic [REG_W-1:0]  move_src;
        logic [KIND_W-1:0] move_kind;
        logic              kind_error;
        logic              last_move;
    } move_t;

    // One pending copy held in a cell
    typedef struct packed {
        logic              pending;
        logic [REG_W-1:0]  dst;
        logic [REG_W-1:0]  src;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // Broadcast from chain to every cell
    typedef struct packed {
        logic [1:0]        op;
        logic [REG_W-1:0]  dst;
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  temp;
    } cell_bcast_t;

    // Sequencer to chain
    typedef struct packed {
        logic [1:0]       op;
        logic             load;
        logic             drop_head;
        logic [REG_W-1:0] temp;
    } chain_ctrl_t;

    // Chain to sequencer
    typedef struct packed {
        entry_t head;
        logic   any_pending;
        logic   others_pending;
        logic   head_read;
        logic   redir_err;
    } chain_stat_t;

endpackage

`default_nettype wire

// File: design/pcs_cell.sv
// ----------------------------------------------------------------------------
// Copy cell
// Holds one pending copy, shifts toward the head and compares its source
// against the broadcast destination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcs_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  pcs_pkg::cell_bcast_t bcast,
    input  pcs_pkg::entry_t      shift_in,
    output pcs_pkg::entry_t      entry,
    output logic                 match,
    output logic                 kind_mismatch
);
    import pcs_pkg::*;

    logic              pending_reg, pending_next;
    logic [REG_W-1:0]  dst_reg, dst_next;
    logic [REG_W-1:0]  src_reg, src_next;
    logic [KIND_W-1:0] kind_reg, kind_next;

    // Reader check against broadcast register
    assign match         = pending_reg && (src_reg == bcast.dst);
    assign kind_mismatch = match && (kind_reg != bcast.kind);

    assign entry = '{pending: pending_reg, dst: dst_reg, src: src_reg, kind: kind_reg};

    // Next-state per opcode
    always_comb
    begin
        pending_next = pending_reg;
        dst_next     = dst_reg;
        src_next     = src_reg;
        kind_next    = kind_reg;
        case (bcast.op)
            CELL_SHIFT:
            begin
                pending_next = shift_in.pending;
                dst_next     = shift_in.dst;
                src_next     = shift_in.src;
                kind_next    = shift_in.kind;
            end
            CELL_REDIR:
            begin
                if (match)
                begin
                    src_next = bcast.temp;
                end
            end
            CELL_CLEAR:
            begin
                pending_next = 1'b0;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    // Control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        dst_reg  <= dst_next;
        src_reg  <= src_next;
        kind_reg <= kind_next;
    end

endmodule

`default_nettype wire

// File: design/pcs_chain.sv
// ----------------------------------------------------------------------------
// Copy chain
// Ring of copy cells. Loads enter at the tail; rotation moves the head entry
// back to the tail, dropping it when it has been emitted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcs_chain (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pcs_pkg::chain_ctrl_t ctrl,
    input  pcs_pkg::copy_req_t   copy_in,
    output pcs_pkg::chain_stat_t stat
);
    import pcs_pkg::*;

    entry_t                cell_q [MAX_COPIES];
    entry_t                tail_in;
    cell_bcast_t           bcast;
    logic [MAX_COPIES-1:0] match;
    logic [MAX_COPIES-1:0] kmis;
    logic [MAX_COPIES-1:0] pend;

    // Head entry drives the compare bus
    always_comb
    begin
        bcast.op   = ctrl.op;
        bcast.dst  = cell_q[0].dst;
        bcast.kind = cell_q[0].kind;
        bcast.temp = ctrl.temp;
    end

    // Tail feed: new copy on load, else recirculated head
    always_comb
    begin
        if (ctrl.load)
        begin
            tail_in.pending = 1'b1;
            tail_in.dst     = copy_in.copy_dst;
            tail_in.src     = copy_in.copy_src;
            tail_in.kind    = copy_in.copy_kind;
        end
        else
        begin
            tail_in         = cell_q[0];
            tail_in.pending = cell_q[0].pending && !ctrl.drop_head;
        end
    end

    // Cell row
    for (genvar i = 0; i < MAX_COPIES; i++)
    begin : g_cell
        entry_t nbr;
        if (i == MAX_COPIES - 1)
        begin : g_tail
            assign nbr = tail_in;
        end
        else
        begin : g_body
            assign nbr = cell_q[i+1];
        end

        pcs_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .bcast         (bcast),
            .shift_in      (nbr),
            .entry         (cell_q[i]),
            .match         (match[i]),
            .kind_mismatch (kmis[i])
        );

        assign pend[i] = cell_q[i].pending;
    end

    // Status reductions; head excluded from reader check
    always_comb
    begin
        stat.head           = cell_q[0];
        stat.any_pending    = |pend;
        stat.others_pending = |pend[MAX_COPIES-1:1];
        stat.head_read      = |match[MAX_COPIES-1:1];
        stat.redir_err      = |kmis;
    end

endmodule

`default_nettype wire

// File: design/parallel_copy_sequencer_core.sv
// ----------------------------------------------------------------------------
// Parallel copy sequencer
// Loads a batch of parallel copies into a ring of cells and emits an ordered
// list of single moves, breaking cycles through fresh temporaries.
//
//   channel  | dir | handshake             | payload
//   copy     | in  | copy_valid/copy_stall | copy_req_t
//   move     | out | move_valid/move_stall | move_t
//   cfg      | in  | cfg_wr_en             | cfg_wr_data (temp_base)
//
// Loading: one cycle per copy; copies beyond MAX_COPIES are dropped.
// Emission: each pass rotates the full ring; a cycle break seeks the first
//   pending copy, saves its dst in a temp and realigns the ring, skipping the
//   realign when the first pending copy is already at the head.
// A clear state ends the batch; copy_stall is high from last copy until it ends.
// Reset clears all pending copies, counters and temp_base; a stalled move
//   holds the sequencer in place during scan and seek.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module parallel_copy_sequencer_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 copy_valid,
    output logic                copy_stall,
    input  pcs_pkg::copy_req_t  copy,
    output logic                move_valid,
    input  wire                 move_stall,
    output pcs_pkg::move_t      move,
    input  wire                 cfg_wr_en,
    input  wire [15:0]          cfg_wr_data
);
    import pcs_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SEEK  = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             progress_reg, progress_next;
    logic [MCNT_W-1:0] mcnt_reg, mcnt_next;
    logic [REG_W-1:0] temps_used_reg, temps_used_next;
    logic [REG_W-1:0] temp_base_reg;
    logic             out_valid_reg;
    move_t            out_data_reg;

    chain_ctrl_t      ctrl;
    chain_stat_t      stat;
    logic             copy_acc;
    logic             out_free;
    logic [REG_W-1:0] temp_num;
    logic             last_pos;
    logic             cap_last;
    logic [POS_W-1:0] pos_inc;
    logic             emit;
    move_t            emit_data;
    logic             emit_now;

    pcs_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .copy_in (copy),
        .stat    (stat)
    );

    assign copy_stall = (state_reg != ST_LOAD);
    assign copy_acc   = copy_valid && !copy_stall;
    assign out_free   = !out_valid_reg || !move_stall;
    assign temp_num   = temp_base_reg + temps_used_reg;
    assign last_pos   = (pos_reg == POS_W'(MAX_COPIES - 1));
    assign cap_last   = (mcnt_reg == MCNT_W'(MAX_MOVES - 1));
    assign pos_inc    = last_pos ? '0 : pos_reg + POS_W'(1);
    assign emit_now   = stat.head.pending && !stat.head_read;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        progress_next   = progress_reg;
        mcnt_next       = mcnt_reg;
        temps_used_next = temps_used_reg;
        ctrl.op         = CELL_HOLD;
        ctrl.load       = 1'b0;
        ctrl.drop_head  = 1'b0;
        ctrl.temp       = temp_num;
        emit            = 1'b0;
        emit_data       = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (copy_acc)
                begin
                    if (count_reg != CNT_W'(MAX_COPIES))
                    begin
                        ctrl.op    = CELL_SHIFT;
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (copy.last_copy)
                    begin
                        state_next    = ST_SCAN;
                        pos_next      = '0;
                        progress_next = 1'b0;
                        mcnt_next     = '0;
                    end
                end
            end

            // One head entry per cycle while the move output is free; emit if nobody still reads its dst
            ST_SCAN:
            begin
                if (out_free)
                begin
                    ctrl.op        = CELL_SHIFT;
                    ctrl.drop_head = emit_now;
                    pos_next       = pos_inc;
                    if (emit_now)
                    begin
                        emit                 = 1'b1;
                        emit_data.move_dst   = stat.head.dst;
                        emit_data.move_src   = stat.head.src;
                        emit_data.move_kind  = stat.head.kind;
                        emit_data.kind_error = 1'b0;
                        emit_data.last_move  = cap_last || !stat.others_pending;
                        mcnt_next            = mcnt_reg + MCNT_W'(1);
                    end
                    if (emit_now && (cap_last || !stat.others_pending))
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (last_pos)
                    begin
                        progress_next = 1'b0;
                        if (!(progress_reg || emit_now))
                        begin
                            state_next = ST_SEEK;
                        end
                    end
                    else
                    begin
                        progress_next = progress_reg || emit_now;
                    end
                end
            end

            // Rotate to first pending copy, then save its dst in a temp
            ST_SEEK:
            begin
                if (out_free)
                begin
                    if (stat.head.pending)
                    begin
                        ctrl.op              = CELL_REDIR;
                        emit                 = 1'b1;
                        emit_data.move_dst   = temp_num;
                        emit_data.move_src   = stat.head.dst;
                        emit_data.move_kind  = stat.head.kind;
                        emit_data.kind_error = stat.redir_err;
                        emit_data.last_move  = cap_last;
                        mcnt_next            = mcnt_reg + MCNT_W'(1);
                        temps_used_next      = temps_used_reg + REG_W'(1);
                        if (cap_last)
                        begin
                            state_next = ST_CLEAR;
                        end
                        else if (pos_reg == '0)
                        begin
                            state_next    = ST_SCAN;
                            progress_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_ALIGN;
                        end
                    end
                    else
                    begin
                        ctrl.op  = CELL_SHIFT;
                        pos_next = pos_inc;
                    end
                end
            end

            // Finish the lap so the next pass starts at the first copy
            ST_ALIGN:
            begin
                ctrl.op  = CELL_SHIFT;
                pos_next = pos_inc;
                if (last_pos)
                begin
                    state_next    = ST_SCAN;
                    progress_next = 1'b0;
                end
            end

            ST_CLEAR:
            begin
                ctrl.op    = CELL_CLEAR;
                count_next = '0;
                mcnt_next  = '0;
                state_next = ST_LOAD;
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            pos_reg        <= '0;
            progress_reg   <= 1'b0;
            mcnt_reg       <= '0;
            temps_used_reg <= '0;
            temp_base_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            progress_reg   <= progress_next;
            mcnt_reg       <= mcnt_next;
            temps_used_reg <= temps_used_next;
            if (cfg_wr_en)
            begin
                temp_base_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!move_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Move output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    assign move_valid = out_valid_reg;
    assign move       = out_data_reg;

endmodule

`default_nettype wire

// File: design/pcs_checker.sv
// ----------------------------------------------------------------------------
// Parallel copy sequencer port checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_copy_sequencer_core_macros.svh"

module pcs_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                copy_valid,
    input wire                copy_stall,
    input pcs_pkg::copy_req_t copy,
    input wire                move_valid,
    input wire                move_stall,
    input pcs_pkg::move_t     move,
    input wire                cfg_wr_en,
    input wire [15:0]         cfg_wr_data
);
    import pcs_pkg::*;

    // Batch close stops further copies
    `PCS_ASSERT_NEXT(a_last_copy_stalls, clk, rst_n, copy_valid && !copy_stall && copy.last_copy, copy_stall)

    // Stalled move request holds
    `PCS_ASSERT_NEXT(a_move_hold, clk, rst_n, move_valid && move_stall, move_valid && $stable(move))

    // Only the closing move of a batch may wait while copies are taken
    `PCS_ASSERT_NOW(a_load_only_last, clk, rst_n, move_valid && !copy_stall, move.last_move)

endmodule

bind parallel_copy_sequencer_core pcs_checker u_pcs_checker (.*);

`default_nettype wire
